FILE: hw/rtl/vts_pkg.sv
package vts_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned PITCH_W  = 31;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned PROD_W   = PITCH_W + CELL_W;
  // pitch - (pos - origin - pitch*cell) spans up to 43 signed bits
  localparam int unsigned NUM_W    = 43;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned LIN_W    = 24;
  // grid dimensions run up to 1024
  localparam int unsigned GRID_W   = 11;
  localparam int unsigned ROW_W    = GRID_W + IDX_W;
  localparam int unsigned REM_W    = DIR_W;
  localparam int unsigned FRAC_SH  = 15;
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_STGS = DIST_W / DIV_BITS;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 96;

  // pipeline stage numbering
  localparam int unsigned ST_DIV0    = 3;
  localparam int unsigned ST_PICK    = ST_DIV0 + DIV_STGS;
  localparam int unsigned ST_ROW     = ST_PICK + 1;
  localparam int unsigned ST_OUT     = ST_ROW + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_PITCH_X  = 3'd3,
    REG_PITCH_Y  = 3'd4,
    REG_PITCH_Z  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // cell indices and direction signs that ride alongside the dividers
  typedef struct packed {
    logic [CELL_W-1:0] cell_i;
    logic [CELL_W-1:0] cell_j;
    logic [CELL_W-1:0] cell_k;
    logic [2:0]        dneg;
  } side_t;

  typedef struct packed {
    logic [DIST_W-1:0] face_dist;
    axis_e             axis;
    logic [IDX_W-1:0]  ni;
    logic [IDX_W-1:0]  nj;
    logic [IDX_W-1:0]  nk;
    logic              leaves;
  } pick_t;

endpackage

FILE: hw/rtl/vts_axis.sv
module vts_axis (
  input  logic                           clk_i,
  input  logic [vts_pkg::ST_PICK-1:0]    adv_i,
  input  logic [vts_pkg::POS_W-1:0]      pos_i,
  input  logic [vts_pkg::DIR_W-1:0]      dir_i,
  input  logic [vts_pkg::CELL_W-1:0]     cell_i,
  input  logic [vts_pkg::POS_W-1:0]      origin_i,
  input  logic [vts_pkg::PITCH_W-1:0]    pitch_i,
  output logic [vts_pkg::DIST_W-1:0]     dist_o
);

  localparam int unsigned NW = vts_pkg::NUM_W;
  localparam int unsigned RW = vts_pkg::REM_W;
  localparam int unsigned QW = vts_pkg::DIST_W;
  localparam int unsigned NS = vts_pkg::DIV_STGS;

  // stage 0
  logic [vts_pkg::PROD_W-1:0] prod_q;
  logic [vts_pkg::POS_W-1:0]  pos_q;
  logic [vts_pkg::DIR_W-1:0]  dir_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      prod_q <= vts_pkg::PROD_W'(pitch_i) * vts_pkg::PROD_W'(cell_i);
      pos_q  <= pos_i;
      dir_q  <= dir_i;
    end
  end

  // stage 1: numerator and divisor magnitude
  logic [NW-1:0]              negrel;
  logic [NW-1:0]              num_d, num_q;
  logic [vts_pkg::DIR_W-1:0]  absd_d, absd_q;
  logic                       dzero_q;

  always_comb begin
    negrel = {{(NW-vts_pkg::POS_W){origin_i[vts_pkg::POS_W-1]}}, origin_i}
           + NW'(prod_q)
           - {{(NW-vts_pkg::POS_W){pos_q[vts_pkg::POS_W-1]}}, pos_q};
    num_d  = dir_q[vts_pkg::DIR_W-1] ? negrel : (NW'(pitch_i) + negrel);
    absd_d = dir_q[vts_pkg::DIR_W-1] ? (~dir_q + 1'b1) : dir_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      num_q   <= num_d;
      absd_q  <= absd_d;
      dzero_q <= (dir_q == '0);
    end
  end

  // stage 2: special cases and first remainder; divider stages follow
  logic [RW-1:0]             rem_q  [NS+1];
  logic [QW-1:0]             dq_q   [NS+1];
  logic [vts_pkg::DIR_W-1:0] d_q    [NS+1];
  logic                      zero_q [NS+1];
  logic                      max_q  [NS+1];

  logic          numle0, sat;
  logic [NW-1:0] lim;

  always_comb begin
    numle0 = num_q[NW-1] || (num_q == '0);
    lim    = NW'({absd_q, 17'b0});
    sat    = !num_q[NW-1] && (num_q >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      rem_q[0]  <= num_q[32:17];
      dq_q[0]   <= {num_q[16:0], vts_pkg::FRAC_SH'(0)};
      d_q[0]    <= absd_q;
      zero_q[0] <= numle0 && !dzero_q;
      max_q[0]  <= dzero_q || (!numle0 && sat);
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [RW-1:0] rem_n;
    logic [QW-1:0] dq_n;

    always_comb begin
      logic [RW:0] r2;
      rem_n = rem_q[s];
      dq_n  = dq_q[s];
      for (int b = 0; b < vts_pkg::DIV_BITS; b++) begin
        r2   = {rem_n, dq_n[QW-1]};
        dq_n = {dq_n[QW-2:0], 1'b0};
        if (r2 >= (RW+1)'(d_q[s])) begin
          rem_n   = RW'(r2 - (RW+1)'(d_q[s]));
          dq_n[0] = 1'b1;
        end else begin
          rem_n = RW'(r2);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[vts_pkg::ST_DIV0+s]) begin
        rem_q[s+1]  <= rem_n;
        dq_q[s+1]   <= dq_n;
        d_q[s+1]    <= d_q[s];
        zero_q[s+1] <= zero_q[s];
        max_q[s+1]  <= max_q[s];
      end
    end
  end

  assign dist_o = max_q[NS]  ? '1 :
                  zero_q[NS] ? '0 : dq_q[NS];

endmodule

FILE: hw/rtl/vts_pick.sv
module vts_pick #(
  parameter int unsigned GRID_X = 256,
  parameter int unsigned GRID_Y = 256,
  parameter int unsigned GRID_Z = 256
) (
  input  logic                        clk_i,
  input  logic [2:0]                  adv_i,
  input  logic [vts_pkg::DIST_W-1:0]  dist_x_i,
  input  logic [vts_pkg::DIST_W-1:0]  dist_y_i,
  input  logic [vts_pkg::DIST_W-1:0]  dist_z_i,
  input  vts_pkg::side_t              side_i,
  output vts_pkg::pick_t              res_o,
  output logic [vts_pkg::LIN_W-1:0]   lin_o
);

  localparam int unsigned IW = vts_pkg::IDX_W;
  localparam int unsigned CW = vts_pkg::GRID_W + 1;

  function automatic logic outside(logic [IW-1:0] idx, logic [CW-1:0] lim);
    logic [CW-1:0] ext;
    ext = {{(CW-IW){idx[IW-1]}}, idx};
    return idx[IW-1] || ($signed(ext) >= $signed(lim));
  endfunction

  vts_pkg::pick_t pick_d, pick_q, row_pick_q;
  logic [IW-1:0]  ci, cj, ck;

  always_comb begin
    ci = IW'(side_i.cell_i);
    cj = IW'(side_i.cell_j);
    ck = IW'(side_i.cell_k);
    pick_d.ni = ci;
    pick_d.nj = cj;
    pick_d.nk = ck;
    if (dist_x_i < dist_y_i && dist_x_i < dist_z_i) begin
      pick_d.axis      = vts_pkg::AXIS_X;
      pick_d.face_dist = dist_x_i;
      pick_d.ni        = side_i.dneg[0] ? ci - 1'b1 : ci + 1'b1;
    end else if (dist_y_i < dist_x_i && dist_y_i < dist_z_i) begin
      pick_d.axis      = vts_pkg::AXIS_Y;
      pick_d.face_dist = dist_y_i;
      pick_d.nj        = side_i.dneg[1] ? cj - 1'b1 : cj + 1'b1;
    end else begin
      pick_d.axis      = vts_pkg::AXIS_Z;
      pick_d.face_dist = dist_z_i;
      pick_d.nk        = side_i.dneg[2] ? ck - 1'b1 : ck + 1'b1;
    end
    pick_d.leaves = outside(pick_d.ni, CW'(GRID_X)) ||
                    outside(pick_d.nj, CW'(GRID_Y)) ||
                    outside(pick_d.nk, CW'(GRID_Z));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      pick_q <= pick_d;
    end
  end

  // row offset, then full linear index
  logic [vts_pkg::ROW_W-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      row_q      <= vts_pkg::ROW_W'(pick_q.nk) * vts_pkg::ROW_W'(GRID_Y)
                  + vts_pkg::ROW_W'(pick_q.nj);
      row_pick_q <= pick_q;
    end
  end

  logic [31:0] lin_full;
  assign lin_full = 32'(row_q) * 32'(GRID_X) + 32'(row_pick_q.ni);

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      res_o <= row_pick_q;
      lin_o <= row_pick_q.leaves ? '0 : lin_full[vts_pkg::LIN_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/voxel_traversal_step_core.sv
// One Amanatides-Woo traversal step per ray: from position, direction and
// current voxel it finds the exit-face distance on each axis, steps across
// the nearest face and reports the next voxel, its linear index, or that the
// ray leaves the grid. It takes one item per cycle unless the output stalls,
// through three setup stages, an eight-stage divider producing four quotient
// bits per stage, and three selection and indexing stages. A stalled output
// holds its result while earlier stages keep filling any empty slots. The
// user must write the configuration registers (index 0..2 origin, 3..5 pitch)
// on the cfg channel only while no ray is in flight; the core does not check.
module voxel_traversal_step_core #(
  parameter int unsigned GRID_X = 256,
  parameter int unsigned GRID_Y = 256,
  parameter int unsigned GRID_Z = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, cell_i, cell_j, cell_k
  input  logic [vts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // face_distance, step_axis, next_i, next_j, next_k, next_linear,
  // leaves_grid, zero padding
  output logic [vts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int unsigned NS = vts_pkg::NUM_STAGES;

  logic [vts_pkg::POS_W-1:0]   origin_x_q, origin_y_q, origin_z_q;
  logic [vts_pkg::PITCH_W-1:0] pitch_x_q, pitch_y_q, pitch_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      pitch_x_q  <= vts_pkg::PITCH_W'(65536);
      pitch_y_q  <= vts_pkg::PITCH_W'(65536);
      pitch_z_q  <= vts_pkg::PITCH_W'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vts_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        vts_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        vts_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        vts_pkg::REG_PITCH_X:  pitch_x_q  <= cfg_data_i[vts_pkg::PITCH_W-1:0];
        vts_pkg::REG_PITCH_Y:  pitch_y_q  <= cfg_data_i[vts_pkg::PITCH_W-1:0];
        vts_pkg::REG_PITCH_Z:  pitch_z_q  <= cfg_data_i[vts_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids; a stage advances when it is empty or its successor advances
  logic [NS-1:0] valid_q, adv;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid_q[NS-1];

  logic [31:0] pos_x, pos_y, pos_z;
  logic [15:0] dir_x, dir_y, dir_z;
  logic [7:0]  cell_i, cell_j, cell_k;

  assign pos_x  = s_axis_tdata[31:0];
  assign pos_y  = s_axis_tdata[63:32];
  assign pos_z  = s_axis_tdata[95:64];
  assign dir_x  = s_axis_tdata[111:96];
  assign dir_y  = s_axis_tdata[127:112];
  assign dir_z  = s_axis_tdata[143:128];
  assign cell_i = s_axis_tdata[151:144];
  assign cell_j = s_axis_tdata[159:152];
  assign cell_k = s_axis_tdata[167:160];

  // carry cells and direction signs alongside the dividers
  vts_pkg::side_t side_q [vts_pkg::ST_PICK];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= '{cell_i: cell_i, cell_j: cell_j, cell_k: cell_k,
                     dneg: {dir_z[15], dir_y[15], dir_x[15]}};
    end
    for (int k = 1; k < vts_pkg::ST_PICK; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic [vts_pkg::DIST_W-1:0] dist_x, dist_y, dist_z;

  vts_axis u_axis_x (
    .clk_i, .adv_i(adv[vts_pkg::ST_PICK-1:0]), .pos_i(pos_x), .dir_i(dir_x),
    .cell_i(cell_i), .origin_i(origin_x_q), .pitch_i(pitch_x_q), .dist_o(dist_x)
  );

  vts_axis u_axis_y (
    .clk_i, .adv_i(adv[vts_pkg::ST_PICK-1:0]), .pos_i(pos_y), .dir_i(dir_y),
    .cell_i(cell_j), .origin_i(origin_y_q), .pitch_i(pitch_y_q), .dist_o(dist_y)
  );

  vts_axis u_axis_z (
    .clk_i, .adv_i(adv[vts_pkg::ST_PICK-1:0]), .pos_i(pos_z), .dir_i(dir_z),
    .cell_i(cell_k), .origin_i(origin_z_q), .pitch_i(pitch_z_q), .dist_o(dist_z)
  );

  vts_pkg::pick_t            res;
  logic [vts_pkg::LIN_W-1:0] lin;

  vts_pick #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)
  ) u_pick (
    .clk_i,
    .adv_i   (adv[vts_pkg::ST_OUT:vts_pkg::ST_PICK]),
    .dist_x_i(dist_x),
    .dist_y_i(dist_y),
    .dist_z_i(dist_z),
    .side_i  (side_q[vts_pkg::ST_PICK-1]),
    .res_o   (res),
    .lin_o   (lin)
  );

  assign m_axis_tdata = {7'b0, res.leaves, lin, res.nk, res.nj, res.ni,
                         res.axis, res.face_dist};

endmodule

FILE: hw/rtl/vts_checker.sv
module vts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // an empty output stage means every stage can take a transfer
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");

  a_leave_lin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[88] |-> m_axis_tdata[87:64] == 24'd0)
    else $error("linear index set on a ray leaving the grid");

  a_axis_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad step axis");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind voxel_traversal_step_core vts_checker u_vts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
